>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TFC_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TFC_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> rtl/core/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tfc_pkg;

    localparam int VERTEX_BITS = 20;
    localparam int MAX_FACES   = 4096;
    localparam int MAX_TETS    = 4096;
    localparam int FACE_AW     = $clog2(MAX_FACES);
    localparam int FACE_CW     = $clog2(MAX_FACES + 1);
    localparam int TET_CW      = $clog2(MAX_TETS + 1);
    localparam int KEY_W       = 3 * VERTEX_BITS;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TAKEN  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_TETLIM = 2'd3;

    localparam logic [1:0] LAST_SLOT = 2'd3;

    typedef struct packed {
        logic load;       // capture the tetrahedron, slot to zero
        logic key_load;   // build the key of the current facet
        logic rd;         // read the face entry at the search index
        logic found_set;  // search hit at the current index
        logic idx_inc;    // advance the search index
        logic commit;     // produce the result and update the tables
        logic slot_inc;   // go to the next facet
        logic tet_inc;    // bump the tetrahedron count
    } tfc_cmd_t;

    typedef struct packed {
        logic tet_lim;
        logic idx_end;
        logic match;
        logic out_busy;
        logic last_slot;
    } tfc_stat_t;

endpackage

>>> rtl/core/tfc_datapath.sv
// ----------------------------------------------------------------------------
// tfc_datapath
// Facet key sort, face key and side tables, counters and result register.
// ----------------------------------------------------------------------------
module tfc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tfc_pkg::VERTEX_BITS-1:0]   vertex_0,
    input  logic [tfc_pkg::VERTEX_BITS-1:0]   vertex_1,
    input  logic [tfc_pkg::VERTEX_BITS-1:0]   vertex_2,
    input  logic [tfc_pkg::VERTEX_BITS-1:0]   vertex_3,
    input  tfc_pkg::tfc_cmd_t                 cmd,
    output tfc_pkg::tfc_stat_t                stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [11:0]                       tet_number,
    output logic [1:0]                        facet_slot,
    output logic [11:0]                       face_number,
    output logic                              face_side,
    output logic                              new_face,
    output logic [1:0]                        status,
    output logic                              last
);

    localparam int VB = tfc_pkg::VERTEX_BITS;
    localparam int AW = tfc_pkg::FACE_AW;
    localparam int CW = tfc_pkg::FACE_CW;
    localparam int TW = tfc_pkg::TET_CW;
    localparam int KW = tfc_pkg::KEY_W;

    logic [KW-1:0] key_mem [tfc_pkg::MAX_FACES];
    logic [1:0]    side_mem [tfc_pkg::MAX_FACES];

    logic [VB-1:0] v0_reg, v1_reg, v2_reg, v3_reg;
    logic [1:0]    slot_reg;
    logic [KW-1:0] key_reg;
    logic          side_reg;
    logic [CW-1:0] idx_reg;
    logic          found_reg;
    logic [CW-1:0] face_cnt_reg;
    logic [TW-1:0] tet_cnt_reg;
    logic [KW-1:0] key_rd_reg;
    logic [1:0]    side_rd_reg;

    logic          out_valid_reg;
    logic [11:0]   tet_number_reg;
    logic [1:0]    facet_slot_reg;
    logic [11:0]   face_number_reg;
    logic          face_side_reg;
    logic          new_face_reg;
    logic [1:0]    status_reg;
    logic          last_reg;

    logic [VB-1:0] a, b, c, k0, k1, k2, t;
    logic          par;
    logic          full;
    logic          taken;
    logic [1:0]    side_bit;

    // Select the facet corners and sort them with the three-pair network.
    always_comb
    begin
        case (slot_reg)
            2'd0:
            begin
                a = v1_reg; b = v3_reg; c = v2_reg;
            end
            2'd1:
            begin
                a = v0_reg; b = v2_reg; c = v3_reg;
            end
            2'd2:
            begin
                a = v0_reg; b = v3_reg; c = v1_reg;
            end
            default:
            begin
                a = v0_reg; b = v1_reg; c = v2_reg;
            end
        endcase
        k0 = a; k1 = b; k2 = c; par = 1'b0; t = '0;
        if (k1 < k0)
        begin
            t = k1; k1 = k0; k0 = t; par = ~par;
        end
        if (k2 < k0)
        begin
            t = k2; k2 = k0; k0 = t; par = ~par;
        end
        if (k2 < k1)
        begin
            t = k2; k2 = k1; k1 = t; par = ~par;
        end
    end

    assign full     = (face_cnt_reg == CW'(tfc_pkg::MAX_FACES));
    assign side_bit = side_reg ? 2'b10 : 2'b01;
    assign taken    = |(side_rd_reg & side_bit);

    assign stat.tet_lim   = (tet_cnt_reg == TW'(tfc_pkg::MAX_TETS));
    assign stat.idx_end   = (idx_reg == face_cnt_reg);
    assign stat.match     = (key_rd_reg == key_reg);
    assign stat.out_busy  = out_valid_reg & ~out_ready;
    assign stat.last_slot = (slot_reg == tfc_pkg::LAST_SLOT);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v0_reg <= vertex_0;
            v1_reg <= vertex_1;
            v2_reg <= vertex_2;
            v3_reg <= vertex_3;
        end
        if (cmd.key_load)
        begin
            key_reg  <= {k2, k1, k0};
            side_reg <= par;
        end
        if (cmd.rd)
        begin
            key_rd_reg  <= key_mem[idx_reg[AW-1:0]];
            side_rd_reg <= side_mem[idx_reg[AW-1:0]];
        end
        if (cmd.commit && !stat.tet_lim)
        begin
            if (found_reg)
            begin
                if (!taken)
                    side_mem[idx_reg[AW-1:0]] <= side_rd_reg | side_bit;
            end
            else if (!full)
            begin
                key_mem[face_cnt_reg[AW-1:0]]  <= key_reg;
                side_mem[face_cnt_reg[AW-1:0]] <= side_bit;
            end
        end
        if (cmd.commit)
        begin
            tet_number_reg <= tet_cnt_reg[11:0];
            facet_slot_reg <= slot_reg;
            last_reg       <= (slot_reg == tfc_pkg::LAST_SLOT);
            if (stat.tet_lim)
            begin
                face_number_reg <= '0;
                face_side_reg   <= 1'b0;
                new_face_reg    <= 1'b0;
                status_reg      <= tfc_pkg::ST_TETLIM;
            end
            else if (found_reg)
            begin
                face_number_reg <= idx_reg[11:0];
                face_side_reg   <= side_reg;
                new_face_reg    <= 1'b0;
                status_reg      <= taken ? tfc_pkg::ST_TAKEN : tfc_pkg::ST_OK;
            end
            else if (full)
            begin
                face_number_reg <= '0;
                face_side_reg   <= side_reg;
                new_face_reg    <= 1'b0;
                status_reg      <= tfc_pkg::ST_FULL;
            end
            else
            begin
                face_number_reg <= face_cnt_reg[11:0];
                face_side_reg   <= side_reg;
                new_face_reg    <= 1'b1;
                status_reg      <= tfc_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            face_cnt_reg  <= '0;
            tet_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                slot_reg <= '0;
            else if (cmd.slot_inc)
                slot_reg <= slot_reg + 2'd1;
            if (cmd.key_load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.found_set)
                found_reg <= 1'b1;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + CW'(1);
            if (cmd.commit && !stat.tet_lim && !found_reg && !full)
                face_cnt_reg <= face_cnt_reg + CW'(1);
            if (cmd.tet_inc)
                tet_cnt_reg <= tet_cnt_reg + TW'(1);
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tet_number  = tet_number_reg;
    assign facet_slot  = facet_slot_reg;
    assign face_number = face_number_reg;
    assign face_side   = face_side_reg;
    assign new_face    = new_face_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

>>> rtl/core/tfc_ctrl.sv
// ----------------------------------------------------------------------------
// tfc_ctrl
// Sequencer: per facet, key build, linear face search, then result commit.
// ----------------------------------------------------------------------------
module tfc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tfc_pkg::tfc_stat_t stat,
    output tfc_pkg::tfc_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_KEY  = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_FIN  = 5'b10000
    } tfc_state_t;

    tfc_state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                cmd.key_load = 1'b1;
                state_next   = stat.tet_lim ? S_FIN : S_RD;
            end
            S_RD:
            begin
                if (stat.idx_end)
                    state_next = S_FIN;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.match)
                begin
                    cmd.found_set = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_FIN:
            begin
                // Wait until the result register can take a new item.
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    if (stat.last_slot)
                    begin
                        cmd.tet_inc = ~stat.tet_lim;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.slot_inc = 1'b1;
                        state_next   = S_KEY;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/core/tet_face_connectivity.sv
// ----------------------------------------------------------------------------
// tet_face_connectivity
// Builds face adjacency for a tetrahedral mesh, one tetrahedron per item.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with four vertex indices per item. Each
// item is numbered in arrival order and gives exactly four result items, one
// per facet in slot order, on the out_valid/out_ready channel; last marks
// the fourth.
// Each facet builds its sorted key, then for every face that the linear
// search visits does one memory read and one compare; when the key is
// absent, one more step reaches the end of the table. The facet then
// commits its result. The time that an item takes thus grows with the
// number of stored faces in the single-port key table. A tetrahedron past
// the limit skips the search and goes from key build straight to commit.
// The result register parts the two sides: the next item is accepted while
// the fourth result of the previous one still waits. When the receiver
// stalls, the sequencer holds at the commit of the next facet.
// Reset clears the face and tetrahedron counts; the tables need no clearing
// because only entries below the face count are ever read.
// ----------------------------------------------------------------------------
module tet_face_connectivity (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tfc_pkg::VERTEX_BITS-1:0] vertex_0,
    input  logic [tfc_pkg::VERTEX_BITS-1:0] vertex_1,
    input  logic [tfc_pkg::VERTEX_BITS-1:0] vertex_2,
    input  logic [tfc_pkg::VERTEX_BITS-1:0] vertex_3,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [11:0]                     tet_number,
    output logic [1:0]                      facet_slot,
    output logic [11:0]                     face_number,
    output logic                            face_side,
    output logic                            new_face,
    output logic [1:0]                      status,
    output logic                            last
);

    tfc_pkg::tfc_cmd_t  cmd;
    tfc_pkg::tfc_stat_t stat;

    tfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tfc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .vertex_0    (vertex_0),
        .vertex_1    (vertex_1),
        .vertex_2    (vertex_2),
        .vertex_3    (vertex_3),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tet_number  (tet_number),
        .facet_slot  (facet_slot),
        .face_number (face_number),
        .face_side   (face_side),
        .new_face    (new_face),
        .status      (status),
        .last        (last)
    );

endmodule

>>> rtl/core/tfc_checker.sv
// ----------------------------------------------------------------------------
// tfc_checker
// Port-level checks on the result channel of the face connectivity block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  facet_slot,
    input logic [11:0] face_number,
    input logic        face_side,
    input logic        new_face,
    input logic [1:0]  status,
    input logic        last
);

    logic tetlim_out;

    assign tetlim_out = out_valid && (status == tfc_pkg::ST_TETLIM);

    `TFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `TFC_ASSERT_IMP(a_last_slot, out_valid, last == (facet_slot == tfc_pkg::LAST_SLOT))
    `TFC_ASSERT_IMP(a_new_ok, out_valid && new_face, status == tfc_pkg::ST_OK)
    `TFC_ASSERT_IMP(a_tetlim_zero, tetlim_out, face_number == 12'd0 && !face_side && !new_face)

endmodule

bind tet_face_connectivity tfc_checker u_tfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .facet_slot  (facet_slot),
    .face_number (face_number),
    .face_side   (face_side),
    .new_face    (new_face),
    .status      (status),
    .last        (last)
);

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tet_face_connectivity. Tetrahedra are sent on the
// input channel: first a directed set, then random items drawn mostly from a
// small vertex pool, so that faces are shared, with mirrored neighbors and
// wide random values mixed in. A predictor keeps its own face table and
// queues four expected facet results per item. Each result is compared field
// by field. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module testbench;

    typedef logic [tfc_pkg::VERTEX_BITS-1:0] vtx_t;

    typedef struct {
        logic [11:0] tet;
        logic [1:0]  slot;
        logic [11:0] face;
        logic        side;
        logic        is_new;
        logic [1:0]  st;
        logic        fin;
    } facet_res_t;

    typedef struct {
        vtx_t       v[4];
        bit         typed;   // expectations below hold for all four facets
        logic       exp_new;
        logic [1:0] exp_st;
    } tet_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    vtx_t        vertex_0 = '0, vertex_1 = '0, vertex_2 = '0, vertex_3 = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] tet_number;
    logic [1:0]  facet_slot;
    logic [11:0] face_number;
    logic        face_side;
    logic        new_face;
    logic [1:0]  status;
    logic        last;

    tet_face_connectivity dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state: key -> face index, and the taken sides per face.
    int         face_of_key [logic [3*tfc_pkg::VERTEX_BITS-1:0]];
    bit   [1:0] sides_taken [$];
    int         faces_made = 0;
    int         tets_seen = 0;
    facet_res_t pending_facets [$];

    int errors = 0;
    int checked = 0;
    int sent = 0;
    int phase = 0;
    int send_idle_pct [4] = '{0, 66, 0, 38};
    int recv_stall_pct [4] = '{0, 0, 66, 38};

    function automatic void predict_tet(input vtx_t v[4]);
        int            corner [4][3] = '{'{1, 3, 2}, '{0, 2, 3}, '{0, 3, 1}, '{0, 1, 2}};
        vtx_t          k [3];
        vtx_t          t;
        logic [3*tfc_pkg::VERTEX_BITS-1:0] key;
        facet_res_t    r;
        int            f;
        if (tets_seen >= tfc_pkg::MAX_TETS)
        begin
            for (int s = 0; s < 4; s++)
            begin
                r = '{tets_seen[11:0], s[1:0], 12'd0, 1'b0, 1'b0, tfc_pkg::ST_TETLIM,
                      s[1:0] == tfc_pkg::LAST_SLOT};
                pending_facets.insert(pending_facets.size(), r);
            end
            return;
        end
        for (int s = 0; s < 4; s++)
        begin
            r.tet = tets_seen[11:0];
            r.slot = s[1:0];
            r.fin = (s[1:0] == tfc_pkg::LAST_SLOT);
            r.side = 1'b0;
            r.is_new = 1'b0;
            r.st = tfc_pkg::ST_OK;
            for (int i = 0; i < 3; i++)
                k[i] = v[corner[s][i]];
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < i; j++)
                    if (k[i] < k[j])
                    begin
                        t = k[i];
                        k[i] = k[j];
                        k[j] = t;
                        r.side = ~r.side;
                    end
            key = {k[0], k[1], k[2]};
            if (face_of_key.exists(key))
                f = face_of_key[key];
            else if (faces_made >= tfc_pkg::MAX_FACES)
                f = -1;
            else
            begin
                f = faces_made++;
                face_of_key[key] = f;
                sides_taken.insert(sides_taken.size(), 2'b00);
                r.is_new = 1'b1;
            end
            if (f < 0)
            begin
                r.face = '0;
                r.st = tfc_pkg::ST_FULL;
            end
            else
            begin
                r.face = f[11:0];
                if (sides_taken[f][r.side])
                    r.st = tfc_pkg::ST_TAKEN;
                else
                    sides_taken[f][r.side] = 1'b1;
            end
            pending_facets.insert(pending_facets.size(), r);
        end
        tets_seen++;
    endfunction

    // Receiver: stall at random according to the phase, check on acceptance.
    always @(posedge clk)
    begin
        facet_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_facets.size() == 0)
            begin
                $display("%0t: unexpected result tet %0d slot %0d", $time, tet_number,
                         facet_slot);
                errors++;
            end
            else
            begin
                e = pending_facets.pop_front();
                checked++;
                if (e.tet !== tet_number || e.slot !== facet_slot ||
                    e.face !== face_number || e.side !== face_side ||
                    e.is_new !== new_face || e.st !== status || e.fin !== last)
                begin
                    $display("%0t: expected tet %0d slot %0d face %0d side %0d new %0d st %0d",
                             $time, e.tet, e.slot, e.face, e.side, e.is_new, e.st);
                    $display("%0t:          last %0d", $time, e.fin);
                    $display("%0t: actual   tet %0d slot %0d face %0d side %0d new %0d st %0d",
                             $time, tet_number, facet_slot, face_number, face_side,
                             new_face, status);
                    $display("%0t:          last %0d", $time, last);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct[phase]);
    end

    task automatic send_tet(input vtx_t v[4]);
        while ($urandom_range(99) < send_idle_pct[phase])
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vertex_0 <= v[0];
        vertex_1 <= v[1];
        vertex_2 <= v[2];
        vertex_3 <= v[3];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_tet(v);
        sent++;
    endtask

    function automatic vtx_t pick_vertex(input vtx_t pool[8]);
        case ($urandom_range(3))
            0: return vtx_t'($urandom);
            default: return pool[$urandom_range(7)];
        endcase
    endfunction

    tet_row_t directed [] = '{
        '{'{20'd0, 20'd1, 20'd2, 20'd3}, 1'b1, 1'b1, tfc_pkg::ST_OK},
        '{'{20'd0, 20'd1, 20'd2, 20'd3}, 1'b1, 1'b0, tfc_pkg::ST_TAKEN},
        '{'{20'd1, 20'd0, 20'd2, 20'd3}, 1'b0, 1'b0, tfc_pkg::ST_OK},
        '{'{20'd0, 20'd1, 20'd2, 20'd4}, 1'b0, 1'b0, tfc_pkg::ST_OK},
        '{'{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, 1'b0, 1'b0, tfc_pkg::ST_OK},
        '{'{20'd0, 20'd0, 20'd0, 20'd0}, 1'b0, 1'b0, tfc_pkg::ST_OK},
        '{'{20'hFFFFF, 20'd0, 20'hAAAAA, 20'h55555}, 1'b0, 1'b0, tfc_pkg::ST_OK},
        '{'{20'd0, 20'hFFFFF, 20'hAAAAA, 20'h55555}, 1'b0, 1'b0, tfc_pkg::ST_OK},
        '{'{20'd3, 20'd2, 20'd1, 20'd0}, 1'b0, 1'b0, tfc_pkg::ST_OK},
        '{'{20'd5, 20'd5, 20'd7, 20'd9}, 1'b0, 1'b0, tfc_pkg::ST_OK},
        '{'{20'd9, 20'd7, 20'd5, 20'd5}, 1'b0, 1'b0, tfc_pkg::ST_OK},
        '{'{20'h80000, 20'h40000, 20'h00001, 20'h7FFFF}, 1'b0, 1'b0, tfc_pkg::ST_OK}
    };

    initial
    begin
        vtx_t v [4];
        vtx_t pool [8];
        vtx_t prev [4];
        vtx_t t;
        int   a, b;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < directed.size(); r++)
        begin
            send_tet(directed[r].v);
            // The first two rows have results that can be read off directly:
            // a fresh tetrahedron makes faces 0 to 3, the repeat hits them all.
            if (directed[r].typed)
                for (int s = 0; s < 4; s++)
                begin
                    pending_facets[pending_facets.size() - 4 + s] =
                        '{r[11:0], s[1:0], s[11:0], ~s[0], directed[r].exp_new,
                          directed[r].exp_st, s[1:0] == tfc_pkg::LAST_SLOT};
                end
        end

        foreach (pool[i])
            pool[i] = vtx_t'($urandom);
        prev = directed[0].v;
        for (int n = 0; n < 130; n++)
        begin
            phase = n / 33;
            if ($urandom_range(2) == 0)
            begin
                // Neighbor: swap two corners so shared faces flip orientation.
                v = prev;
                a = $urandom_range(3);
                b = (a + 1 + $urandom_range(2)) % 4;
                t = v[a];
                v[a] = v[b];
                v[b] = t;
                if ($urandom_range(1))
                    v[$urandom_range(3)] = pick_vertex(pool);
            end
            else
                foreach (v[i])
                    v[i] = pick_vertex(pool);
            send_tet(v);
            prev = v;
        end
        in_valid <= 1'b0;

        while (pending_facets.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d tetrahedra, checked %0d facet results, %0d faces allocated.",
                 sent, checked, faces_made);
        if (errors == 0 && pending_facets.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Timeout with %0d results outstanding.", pending_facets.size());
        $display("Regression FAIL");
        $finish;
    end
endmodule
